/* sv/psched_pkg.sv */
// Shared types and constants for the preemptive priority scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package psched_pkg;

  localparam int unsigned ARR_W     = 12;
  localparam int unsigned BUR_W     = 8;
  localparam int unsigned PRI_W     = 8;
  localparam int unsigned TIME_W    = 15;
  localparam int unsigned PNUM_W    = 6;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 56;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_TICK,
    ST_OUT_READ,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_e;

  // Entry fields written once at load time
  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [BUR_W-1:0] bur;
    logic [ARR_W-1:0] arr;
  } stat_word_t;

  // Entry fields updated while the schedule runs
  typedef struct packed {
    logic [TIME_W-1:0] comp;
    logic [BUR_W-1:0]  rem;
  } dyn_word_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_rd;
    logic tick;
    logic out_clr;
    logic out_rd;
    logic out_cap;
    logic out_adv;
    logic run_clr;
  } cmd_t;

  typedef struct packed {
    logic left_zero;
    logic scan_end;
    logic out_end;
  } status_t;

endpackage

/* sv/psched_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psched_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/psched_datapath.sv */
// Datapath: process tables, scan/compare unit, tick counter and result register.
// Depends on psched_pkg and psched_ram.
module psched_datapath
  import psched_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [ARR_W-1:0]     arr_i,
  input  logic [BUR_W-1:0]     bur_i,
  input  logic [PRI_W-1:0]     pri_i,
  output status_t              status_o,
  output logic [PNUM_W-1:0]    pnum_o,
  output logic [TIME_W-1:0]    comp_o,
  output logic [TIME_W-1:0]    wait_o,
  output logic [TIME_W-1:0]    turn_o,
  output logic                 drop_o
);

  localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     left_q, left_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic [CW-1:0]     scan_idx_q, scan_idx_d;
  logic              pend_q;
  logic [IW-1:0]     pend_idx_q;
  logic [CW-1:0]     out_idx_q, out_idx_d;

  logic              found_q, found_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic [PRI_W-1:0]  best_pri_q, best_pri_d;
  logic [ARR_W-1:0]  best_arr_q, best_arr_d;
  logic [BUR_W-1:0]  best_rem_q, best_rem_d;

  logic              space;
  logic              load_wr;
  logic              dyn_we;
  logic [IW-1:0]     dyn_waddr;
  dyn_word_t         dyn_wdata;
  logic [IW-1:0]     raddr;
  stat_word_t        stat_wdata;
  stat_word_t        stat_rd;
  dyn_word_t         dyn_rd;
  logic [TIME_W-1:0] tick_inc;
  logic [CW-1:0]     last_idx;
  logic              eligible;
  logic              better;

  assign space      = cnt_q < CW'(MAX_PROCS);
  assign load_wr    = cmd_i.load && space;
  assign tick_inc   = tick_q + TIME_W'(1);
  assign last_idx   = cnt_q - CW'(1);

  assign stat_wdata = '{pri: pri_i, bur: bur_i, arr: arr_i};
  assign dyn_we     = load_wr || (cmd_i.tick && found_q);
  assign dyn_waddr  = cmd_i.tick ? best_idx_q : cnt_q[IW-1:0];
  assign dyn_wdata  = cmd_i.tick ? dyn_word_t'{comp: tick_inc, rem: best_rem_q - BUR_W'(1)}
                                 : dyn_word_t'{comp: TIME_W'(arr_i), rem: bur_i};
  assign raddr      = cmd_i.out_rd ? out_idx_q[IW-1:0] : scan_idx_q[IW-1:0];

  psched_ram #(
    .WIDTH ($bits(stat_word_t)),
    .DEPTH (MAX_PROCS)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (load_wr),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (stat_wdata),
    .raddr_i (raddr),
    .rdata_o (stat_rd)
  );

  psched_ram #(
    .WIDTH ($bits(dyn_word_t)),
    .DEPTH (MAX_PROCS)
  ) u_dyn_ram (
    .clk_i   (clk_i),
    .we_i    (dyn_we),
    .waddr_i (dyn_waddr),
    .wdata_i (dyn_wdata),
    .raddr_i (raddr),
    .rdata_o (dyn_rd)
  );

  // Candidate selection on returning read data
  assign eligible = pend_q && (TIME_W'(stat_rd.arr) <= tick_q) && (dyn_rd.rem != '0);
  assign better   = !found_q || (stat_rd.pri > best_pri_q) ||
                    ((stat_rd.pri == best_pri_q) && (stat_rd.arr < best_arr_q));

  always_comb begin
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_pri_d = best_pri_q;
    best_arr_d = best_arr_q;
    best_rem_d = best_rem_q;
    if (cmd_i.scan_clr) begin
      found_d = 1'b0;
    end else if (eligible && better) begin
      found_d    = 1'b1;
      best_idx_d = pend_idx_q;
      best_pri_d = stat_rd.pri;
      best_arr_d = stat_rd.arr;
      best_rem_d = dyn_rd.rem;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    left_d     = left_q;
    tick_d     = tick_q;
    scan_idx_d = scan_idx_q;
    out_idx_d  = out_idx_q;
    if (load_wr) begin
      cnt_d = cnt_q + CW'(1);
      if (bur_i != '0) begin
        left_d = left_q + CW'(1);
      end
    end
    if (cmd_i.load && !space) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.tick) begin
      tick_d = tick_inc;
      if (found_q && best_rem_q == BUR_W'(1)) begin
        left_d = left_q - CW'(1);
      end
    end
    if (cmd_i.scan_clr) begin
      scan_idx_d = '0;
    end else if (cmd_i.scan_rd) begin
      scan_idx_d = scan_idx_q + CW'(1);
    end
    if (cmd_i.out_clr) begin
      out_idx_d = '0;
    end else if (cmd_i.out_adv) begin
      out_idx_d = out_idx_q + CW'(1);
    end
    if (cmd_i.run_clr) begin
      cnt_d  = '0;
      ovf_d  = 1'b0;
      left_d = '0;
      tick_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      left_q     <= '0;
      tick_q     <= '0;
      scan_idx_q <= '0;
      out_idx_q  <= '0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      left_q     <= left_d;
      tick_q     <= tick_d;
      scan_idx_q <= scan_idx_d;
      out_idx_q  <= out_idx_d;
      pend_q     <= cmd_i.scan_rd;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= scan_idx_q[IW-1:0];
    best_idx_q <= best_idx_d;
    best_pri_q <= best_pri_d;
    best_arr_q <= best_arr_d;
    best_rem_q <= best_rem_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_cap) begin
      pnum_o <= PNUM_W'(out_idx_q);
      comp_o <= dyn_rd.comp;
      wait_o <= dyn_rd.comp - TIME_W'(stat_rd.bur) - TIME_W'(stat_rd.arr);
      turn_o <= dyn_rd.comp - TIME_W'(stat_rd.arr);
      drop_o <= ovf_q;
    end
  end

  assign status_o.left_zero = (left_q == '0);
  assign status_o.scan_end  = (scan_idx_q == last_idx);
  assign status_o.out_end   = (out_idx_q == last_idx);

endmodule

/* sv/psched_ctrl.sv */
// Controller state machine: sequences load, per-tick scan and result delivery.
// Depends on psched_pkg.
module psched_ctrl
  import psched_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  input  logic    s_tlast_i,
  input  logic    m_tready_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    s_tready_o,
  output logic    m_tvalid_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (s_tvalid_i && s_tlast_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.left_zero ? ST_OUT_READ : ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_end) state_d = ST_DRAIN;
      end
      ST_DRAIN:    state_d = ST_TICK;
      ST_TICK:     state_d = ST_CHECK;
      ST_OUT_READ: state_d = ST_OUT_LOAD;
      ST_OUT_LOAD: state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (m_tready_i) state_d = status_i.out_end ? ST_LOAD : ST_OUT_READ;
      end
      default:     state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      ST_CHECK: begin
        cmd_o.scan_clr = 1'b1;
        cmd_o.out_clr  = 1'b1;
      end
      ST_SCAN:     cmd_o.scan_rd = 1'b1;
      ST_DRAIN:    cmd_o = '0;
      ST_TICK:     cmd_o.tick = 1'b1;
      ST_OUT_READ: cmd_o.out_rd = 1'b1;
      ST_OUT_LOAD: cmd_o.out_cap = 1'b1;
      ST_OUT_WAIT: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          cmd_o.out_adv = 1'b1;
          cmd_o.run_clr = status_i.out_end;
        end
      end
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/preemptive_priority_scheduler_core.sv */
// Preemptive priority scheduler core.
// Load side (s_axis): one request per process, carrying arrival tick, burst
// length and priority; tlast marks the final process and starts the run.
// Loads beyond MAX_PROCS are dropped and reported in the result tuser bit.
// Result side (m_axis): one request per loaded process, in load order, with
// completion, waiting and turnaround times; tlast marks the final result.
// Loads are taken back to back while the load side is open. A run then simulates
// every tick with a scan of the process table, one entry per cycle from a read
// address shared by both table RAMs; ticks run up to the last completion
// (latest arrival plus total burst at most). Each result is then read,
// captured and handed over.
// Only one set is in flight: s_axis_tready is low from the final load until
// the final result is taken. A stalled receiver holds the result register
// and the schedule waits; nothing is dropped.
// Reset returns to the load state with an empty set; table contents stay
// undefined and are only read after being loaded.
// Depends on psched_pkg, psched_ctrl, psched_datapath, psched_ram.
module preemptive_priority_scheduler_core
  import psched_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [11:0] arrival_time, [19:12] burst_length, [27:20] priority_level, [31:28] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,   // last_process
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [5:0] process_number, [20:6] completion_time, [35:21] waiting_time,
  // [50:36] turnaround_time, [55:51] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tuser,   // dropped_flag
  output logic                 m_axis_tlast    // last_result
);

  cmd_t              cmd;
  status_t           status;
  logic [PNUM_W-1:0] pnum;
  logic [TIME_W-1:0] comp;
  logic [TIME_W-1:0] wait_t;
  logic [TIME_W-1:0] turn;
  logic              out_last_q;

  psched_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid)
  );

  psched_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .arr_i    (s_axis_tdata[ARR_W-1:0]),
    .bur_i    (s_axis_tdata[ARR_W+BUR_W-1:ARR_W]),
    .pri_i    (s_axis_tdata[ARR_W+BUR_W+PRI_W-1:ARR_W+BUR_W]),
    .status_o (status),
    .pnum_o   (pnum),
    .comp_o   (comp),
    .wait_o   (wait_t),
    .turn_o   (turn),
    .drop_o   (m_axis_tuser)
  );

  // Capture the last-result mark together with the result fields
  always_ff @(posedge clk_i) begin
    if (cmd.out_cap) begin
      out_last_q <= status.out_end;
    end
  end

  assign m_axis_tlast = out_last_q;
  assign m_axis_tdata = {(M_TDATA_W - PNUM_W - 3 * TIME_W)'(0), turn, wait_t, comp, pnum};

endmodule

/* sv/psched_checker.sv */
// Port-level checker for the scheduler core, attached by bind.
// Depends on psched_pkg and preemptive_priority_scheduler_core.
module psched_checker
  import psched_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // Loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("load and result sides active together");

  // Final load closes the load side
  a_last_load_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("load side open after final load");

  // Taking the final result reopens the load side
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("load side not reopened after final result");

  // More results follow a non-final result before loading resumes
  a_more_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
    else $error("load side opened before final result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind preemptive_priority_scheduler_core psched_checker u_psched_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/preemptive_priority_scheduler_core_tb.sv */
// Testbench for preemptive_priority_scheduler_core: loads process sets over the
// request stream and checks every result against an in-bench schedule predictor.
// Depends on psched_pkg and the core RTL only.
`timescale 1ns / 100ps

module preemptive_priority_scheduler_core_tb;
  import psched_pkg::*;

  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic [PNUM_W-1:0] pnum;
    logic [TIME_W-1:0] comp;
    logic [TIME_W-1:0] waited;
    logic [TIME_W-1:0] turn;
    logic              dropped;
    logic              last;
  } sched_result_t;

  // Holds the process set being loaded and the results its run must produce.
  class schedule_checker;
    logic [ARR_W-1:0] arr_tab [MAX_PROCS];
    logic [BUR_W-1:0] bur_tab [MAX_PROCS];
    logic [PRI_W-1:0] pri_tab [MAX_PROCS];
    int unsigned      held;
    bit               overflow;
    sched_result_t    due_results [$];
    int unsigned      taken;
    int unsigned      errors;

    // Store one accepted request; on the final one, play the schedule tick by tick.
    function void note_load(logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur,
                            logic [PRI_W-1:0] pri, logic last);
      int unsigned   rem [MAX_PROCS];
      int unsigned   done_at [MAX_PROCS];
      int unsigned   tick;
      int unsigned   left;
      int unsigned   pick;
      bit            found;
      sched_result_t r;
      if (held < MAX_PROCS) begin
        arr_tab[held] = arr;
        bur_tab[held] = bur;
        pri_tab[held] = pri;
        held++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;

      left = 0;
      for (int i = 0; i < held; i++) begin
        rem[i]     = bur_tab[i];
        done_at[i] = arr_tab[i];
        if (rem[i] != 0) left++;
      end
      tick = 0;
      while (left != 0) begin
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < held; i++) begin
          if (arr_tab[i] <= tick && rem[i] != 0) begin
            // strict compares keep the earlier load on a full tie
            if (!found || pri_tab[i] > pri_tab[pick] ||
                (pri_tab[i] == pri_tab[pick] && arr_tab[i] < arr_tab[pick])) begin
              pick  = i;
              found = 1'b1;
            end
          end
        end
        tick = (tick + 1) & 32'h7fff;
        if (found) begin
          done_at[pick] = tick;
          rem[pick]--;
          if (rem[pick] == 0) left--;
        end
      end

      for (int i = 0; i < held; i++) begin
        r.pnum    = PNUM_W'(i);
        r.comp    = TIME_W'(done_at[i]);
        r.waited  = TIME_W'(done_at[i] - bur_tab[i] - arr_tab[i]);
        r.turn    = TIME_W'(done_at[i] - arr_tab[i]);
        r.dropped = overflow;
        r.last    = (i + 1 == held);
        due_results.push_back(r);
      end
      held     = 0;
      overflow = 1'b0;
    endfunction

    function void report(string what, sched_result_t want, sched_result_t got);
      errors++;
      if (errors <= MAX_SHOWN) begin
        $display("%0t %s: exp pn=%0d comp=%0d wait=%0d turn=%0d drop=%0b last=%0b",
                 $time, what, want.pnum, want.comp, want.waited, want.turn,
                 want.dropped, want.last);
        $display("%0t %s: got pn=%0d comp=%0d wait=%0d turn=%0d drop=%0b last=%0b",
                 $time, what, got.pnum, got.comp, got.waited, got.turn,
                 got.dropped, got.last);
      end
    endfunction

    // Compare one accepted result with the oldest one still due.
    function void check_result(logic [M_TDATA_W-1:0] data, logic user, logic lst);
      sched_result_t got;
      sched_result_t want;
      got.pnum    = data[5:0];
      got.comp    = data[20:6];
      got.waited  = data[35:21];
      got.turn    = data[50:36];
      got.dropped = user;
      got.last    = lst;
      taken++;
      if (due_results.size() == 0) begin
        want = '0;
        report("unexpected result", want, got);
        return;
      end
      want = due_results.pop_front();
      if (got !== want) report("wrong result", want, got);
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  bit                   tx_quiet = 1'b0;
  bit                   rx_hold  = 1'b0;
  schedule_checker      sb       = new;

  preemptive_priority_scheduler_core #(
    .MAX_PROCS (MAX_PROCS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Sample both handshakes with the values that stood at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_load(s_axis_tdata[11:0], s_axis_tdata[19:12], s_axis_tdata[27:20],
                     s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Offer one process request after a random gap; junk sits on the bus while idle.
  task automatic send_request(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                              input logic [PRI_W-1:0] pri, input logic last);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - ARR_W - BUR_W - PRI_W){1'b0}}, pri, bur, arr};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Result sink: random stalls, with occasional runs of back-to-back acceptance.
  initial begin : result_sink
    int unsigned gap;
    int unsigned quiet_left;
    quiet_left = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (quiet_left != 0) begin
        gap = 0;
        quiet_left--;
      end else begin
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0) quiet_left = 24;
      end
      if (gap != 0 || rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (rx_hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Long back-pressure once results are flowing; the next set piles up at the input.
  initial begin : long_stall
    do @(posedge clk_i); while (!(m_axis_tvalid && sb.taken >= 28));
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #500_000_000;
    $display("preemptive_priority_scheduler_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      set_len;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single process, smallest values
    send_request(12'd0, 8'd1, 8'd0, 1'b1);

    // max fields, zero burst, full tie (load order), arrival tie-break over load
    // order, preemption by a late high priority, idle stretch up to arrival 4095
    send_request(12'd4095, 8'd255, 8'd255, 1'b0);
    send_request(12'd0,    8'd0,   8'd0,   1'b0);
    send_request(12'd4095, 8'd3,   8'd255, 1'b0);
    send_request(12'd10,   8'd4,   8'd7,   1'b0);
    send_request(12'd3,    8'd20,  8'd7,   1'b0);
    send_request(12'd12,   8'd2,   8'd200, 1'b0);
    send_request(12'hAAA,  8'hAA,  8'h55,  1'b1);

    // capacity exceeded: the final request is dropped but still starts the run
    for (int i = 0; i < MAX_PROCS + 1; i++)
      send_request(ARR_W'(i), BUR_W'(1 + i % 2), PRI_W'($urandom), i == MAX_PROCS);

    sent = 0;
    while (sent < 100) begin
      set_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4)
                                             : $urandom_range(1, MAX_PROCS);
      tx_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_len; i++) begin
        // mostly small times so runs stay short; now and then the full range
        arr = ($urandom_range(0, 23) == 0) ? ARR_W'($urandom) : ARR_W'($urandom_range(0, 15));
        case ($urandom_range(0, 31))
          0:       bur = '0;
          1, 2:    bur = BUR_W'($urandom);
          default: bur = BUR_W'($urandom_range(1, 8));
        endcase
        pri = $urandom_range(0, 1) ? PRI_W'($urandom) : PRI_W'($urandom_range(0, 3));
        send_request(arr, bur, pri, i == set_len - 1);
      end
      sent += set_len;
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0)
      $display("preemptive_priority_scheduler_core: match");
    else
      $display("preemptive_priority_scheduler_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
sv/psched_pkg.sv
sv/psched_ram.sv
sv/psched_datapath.sv
sv/psched_ctrl.sv
sv/preemptive_priority_scheduler_core.sv
sv/psched_checker.sv
tb/preemptive_priority_scheduler_core_tb.sv
